FILE: sv/ats_pkg.sv
package ats_pkg;

  localparam int OFFSET_BITS_DEF   = 16;
  localparam int KEYWORD_CHARS_DEF = 7;

  localparam logic [3:0] KIND_IDENT   = 4'd0;
  localparam logic [3:0] KIND_OPCODE  = 4'd1;
  localparam logic [3:0] KIND_SECTION = 4'd2;
  localparam logic [3:0] KIND_NUMBER  = 4'd3;
  localparam logic [3:0] KIND_HEX     = 4'd4;
  localparam logic [3:0] KIND_LPAREN  = 4'd5;
  localparam logic [3:0] KIND_RPAREN  = 4'd6;
  localparam logic [3:0] KIND_LBRACK  = 4'd7;
  localparam logic [3:0] KIND_RBRACK  = 4'd8;
  localparam logic [3:0] KIND_LBRACE  = 4'd9;
  localparam logic [3:0] KIND_RBRACE  = 4'd10;
  localparam logic [3:0] KIND_COLON   = 4'd11;
  localparam logic [3:0] KIND_SEMI    = 4'd12;
  localparam logic [3:0] KIND_UNDER   = 4'd13;

  localparam int         NUM_MNEMONICS = 10;
  localparam logic [55:0] SECTION_WORD = "SECTION";

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [3:0]  opcode_number;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } token_t;

  function automatic logic [23:0] mnemonic(input logic [3:0] idx);
    logic [23:0] m;
    case (idx)
      4'd0:    m = "LR0";
      4'd1:    m = "LR1";
      4'd2:    m = "LR2";
      4'd3:    m = "LR3";
      4'd4:    m = "LB0";
      4'd5:    m = "LB1";
      4'd6:    m = "LB2";
      4'd7:    m = "LB3";
      4'd8:    m = "LDW";
      4'd9:    m = "HLT";
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/ats_if.sv
interface ats_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, output source_byte, output end_of_source, input ready);
  modport sink   (input valid, input source_byte, input end_of_source, output ready);
endinterface

interface ats_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [3:0]  opcode_number;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output opcode_number,
                  output token_start, output token_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input opcode_number,
                  input token_start, input token_length, input last_of_run,
                  output ready);
endinterface

FILE: sv/assembler_token_scanner.sv
// Assembler token scanner.
// in_stream carries one source byte per transfer with an end-of-source flag;
// out_stream carries tokens as kind, opcode number, start offset and length,
// with last_of_run set on the final token caused by a byte.
// Each accepted byte is classified in the cycle it arrives and its tokens
// (none, one or two) are written to a four-entry output queue; a token is
// offered on out_stream once the tokens queued ahead of it are transferred.
// Throughput is one byte per cycle unless ready is low, set by the combinational
// classify and keyword match; in_stream.ready is high while the queue has room
// for two tokens, so a byte that yields two tokens drains through the queue.
// When the receiver stalls, the queue fills and ready drops once three
// tokens are held; queued tokens hold until transferred.
// End of source flushes the pending token and returns the offset to zero.
// Offsets and lengths saturate at 65535 on output.
// Reset empties the queue, clears the offset and leaves the scanner idle.
module assembler_token_scanner #(
  parameter int OFFSET_BITS   = ats_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_CHARS = ats_pkg::KEYWORD_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ats_in_if.sink           in_stream,
  ats_out_if.source        out_stream
);
  import ats_pkg::*;

  localparam int IDX_W   = $clog2(KEYWORD_CHARS);
  localparam int Q_DEPTH = 4;
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [OFFSET_BITS-1:0] OFFS_MAX = '1;

  typedef enum logic [1:0] {MODE_IDLE, MODE_WORD, MODE_NUM} mode_t;
  typedef logic [KEYWORD_CHARS-1:0][7:0] prefix_t;

  mode_t                  mode_r, mode_nxt, mode1;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt, start1;
  logic [OFFSET_BITS-1:0] len_r, len_nxt, len1;
  prefix_t                prefix_r, prefix_nxt, prefix1;
  logic                   hex_r, hex_nxt, hex1;

  token_t                 q_r [Q_DEPTH];
  logic [Q_IDX_W-1:0]     head_r, head_nxt;
  logic [Q_CNT_W-1:0]     count_r, count_nxt;

  logic [7:0]             c;
  logic                   eos, is_letter, is_digit, is_alnum, is_space;
  logic                   punct_hit, restart, f1v, pv, f2v, accept, pop;
  logic [3:0]             p_kind;
  token_t                 f1, pt, f2, w0, w1;
  logic [1:0]             push_n;
  logic [Q_IDX_W-1:0]     wa0, wa1;

  function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] wide;
    wide = {16'b0, v};
    return (wide[OFFSET_BITS+15:16] != '0) ? 16'hFFFF : wide[15:0];
  endfunction

  function automatic token_t make_token(input mode_t m, input logic [OFFSET_BITS-1:0] s,
                                        input logic [OFFSET_BITS-1:0] l, input prefix_t p,
                                        input logic h);
    token_t      r;
    logic [23:0] mn;
    logic        hit;
    logic        sec_ok;
    r.token_kind    = KIND_IDENT;
    r.opcode_number = 4'd0;
    r.token_start   = sat16(s);
    r.token_length  = sat16(l);
    r.last_of_run   = 1'b0;
    hit             = 1'b0;
    sec_ok          = (l == OFFSET_BITS'(7));
    if (m == MODE_NUM) begin
      r.token_kind = h ? KIND_HEX : KIND_NUMBER;
    end else begin
      for (int i = 0; i < NUM_MNEMONICS; i++) begin
        mn = mnemonic(4'(i));
        if (!hit && l == OFFSET_BITS'(3) && p[0] == mn[23:16] && p[1] == mn[15:8]
            && p[2] == mn[7:0]) begin
          hit             = 1'b1;
          r.token_kind    = KIND_OPCODE;
          r.opcode_number = 4'(i);
        end
      end
      for (int j = 0; j < 7; j++) begin
        sec_ok = sec_ok && (p[j] == SECTION_WORD[55-8*j -: 8]);
      end
      if (!hit && sec_ok) begin
        r.token_kind = KIND_SECTION;
      end
    end
    return r;
  endfunction

  assign c         = in_stream.source_byte;
  assign eos       = in_stream.end_of_source;
  assign is_letter = (c inside {["A":"Z"], ["a":"z"]});
  assign is_digit  = (c inside {["0":"9"]});
  assign is_alnum  = is_letter || is_digit;
  assign is_space  = (c == " ") || (c inside {[8'd9:8'd13]});

  always_comb begin
    punct_hit = 1'b1;
    case (c)
      "(":     p_kind = KIND_LPAREN;
      ")":     p_kind = KIND_RPAREN;
      "[":     p_kind = KIND_LBRACK;
      "]":     p_kind = KIND_RBRACK;
      "{":     p_kind = KIND_LBRACE;
      "}":     p_kind = KIND_RBRACE;
      ":":     p_kind = KIND_COLON;
      ";":     p_kind = KIND_SEMI;
      "_":     p_kind = KIND_UNDER;
      default: begin
        p_kind    = KIND_IDENT;
        punct_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode1   = mode_r;
    start1  = start_r;
    len1    = len_r;
    prefix1 = prefix_r;
    hex1    = hex_r;
    restart = !(mode_r != MODE_IDLE && is_alnum);
    f1v     = restart && (mode_r != MODE_IDLE);
    pv      = restart && punct_hit && !is_space;
    if (restart) begin
      mode1 = MODE_IDLE;
      len1  = '0;
      hex1  = 1'b0;
      if (is_alnum) begin
        mode1  = is_letter ? MODE_WORD : MODE_NUM;
        start1 = offset_r;
      end
    end
    if (is_alnum) begin
      if (len1 < OFFSET_BITS'(KEYWORD_CHARS)) begin
        prefix1[len1[IDX_W-1:0]] = c;
      end
      if (mode1 == MODE_NUM && len1 == OFFSET_BITS'(1) && (c == "x" || c == "X")) begin
        hex1 = 1'b1;
      end
      if (len1 != OFFS_MAX) begin
        len1 = len1 + OFFSET_BITS'(1);
      end
    end
    f2v = eos && (mode1 != MODE_IDLE);

    f1 = make_token(mode_r, start_r, len_r, prefix_r, hex_r);
    f2 = make_token(mode1, start1, len1, prefix1, hex1);
    pt.token_kind    = p_kind;
    pt.opcode_number = 4'd0;
    pt.token_start   = sat16(offset_r);
    pt.token_length  = 16'd1;
    pt.last_of_run   = 1'b0;

    w1 = pv ? pt : f2;
    w0 = f1v ? f1 : w1;
    push_n = 2'(f1v) + 2'(pv || f2v);
    if (push_n == 2'd2) begin
      w1.last_of_run = 1'b1;
    end else begin
      w0.last_of_run = 1'b1;
    end

    mode_nxt   = mode1;
    start_nxt  = start1;
    len_nxt    = len1;
    prefix_nxt = prefix1;
    hex_nxt    = hex1;
    offset_nxt = (offset_r == OFFS_MAX) ? offset_r : offset_r + OFFSET_BITS'(1);
    if (eos) begin
      mode_nxt   = MODE_IDLE;
      len_nxt    = '0;
      hex_nxt    = 1'b0;
      offset_nxt = '0;
    end
  end

  assign in_stream.ready = (count_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign accept          = in_stream.valid && in_stream.ready;
  assign out_stream.valid = (count_r != '0);
  assign pop             = out_stream.valid && out_stream.ready;
  assign wa0             = Q_IDX_W'(head_r + count_r[Q_IDX_W-1:0]);
  assign wa1             = Q_IDX_W'(wa0 + Q_IDX_W'(1));

  always_comb begin
    head_nxt  = pop ? Q_IDX_W'(head_r + Q_IDX_W'(1)) : head_r;
    count_nxt = count_r + (accept ? Q_CNT_W'(push_n) : '0) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      offset_r <= '0;
      start_r  <= '0;
      len_r    <= '0;
      hex_r    <= 1'b0;
      head_r   <= '0;
      count_r  <= '0;
    end else begin
      if (accept) begin
        mode_r   <= mode_nxt;
        offset_r <= offset_nxt;
        start_r  <= start_nxt;
        len_r    <= len_nxt;
        hex_r    <= hex_nxt;
      end
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prefix_r <= prefix_nxt;
      if (push_n != 2'd0) begin
        q_r[wa0] <= w0;
      end
      if (push_n == 2'd2) begin
        q_r[wa1] <= w1;
      end
    end
  end

  assign out_stream.token_kind    = q_r[head_r].token_kind;
  assign out_stream.opcode_number = q_r[head_r].opcode_number;
  assign out_stream.token_start   = q_r[head_r].token_start;
  assign out_stream.token_length  = q_r[head_r].token_length;
  assign out_stream.last_of_run   = q_r[head_r].last_of_run;

endmodule
